// ===== rtl/emgnf_pkg.sv =====
// ----------------------------------------------------------------------------
// emgnf_pkg
// Shared widths, codes, reset values and types of the noise floor detector.
// ----------------------------------------------------------------------------
package emgnf_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS    = 10;
    localparam int OFFSET_BITS    = 10;
    localparam int HOLD_BITS      = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MODE_BITS      = 2;

    // default sizing
    localparam int CHANNELS_DEF   = 2;
    localparam int RING_DEPTH_DEF = 16;

    // admission margin is the offset divided by this
    localparam int OFFSET_DIVISOR = 4;
    localparam int OFFSET_SHIFT   = $clog2(OFFSET_DIVISOR);

    // command queue between front and back
    localparam int Q_DEPTH = 2;

    // register reset values
    localparam logic [OFFSET_BITS-1:0] OFFSET_RST      = OFFSET_BITS'(100);
    localparam logic [HOLD_BITS-1:0]   HOLD_RST        = HOLD_BITS'(300);
    localparam logic                   PEAK_ON_END_RST = 1'b0;
    localparam logic [SAMPLE_BITS-1:0] SEED_RST        = SAMPLE_BITS'(512);

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OFFSET      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TIME   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_ON_END = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FLOOR_SEED  = 2'd3;

    // input modes
    localparam logic [MODE_BITS-1:0] MODE_SAMPLE  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_TICK    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RESTART = 2'd2;

    // timer saturation value
    localparam logic [HOLD_BITS-1:0] TICKS_MAX = '1;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] sensitivity_offset;
        logic [HOLD_BITS-1:0]   hold_time;
        logic                   peak_on_end;
        logic [SAMPLE_BITS-1:0] floor_seed;
    } t_cfg;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic                   channel;
        logic [SAMPLE_BITS-1:0] sample_value;
    } t_cmd;

endpackage

// ===== rtl/emgnf_in_if.sv =====
// ----------------------------------------------------------------------------
// emgnf_in_if
// Input channel: one sample, tick or restart word with valid/ready.
// ----------------------------------------------------------------------------
interface emgnf_in_if
    import emgnf_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [MODE_BITS-1:0]   mode;
    logic                   channel;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output mode, output channel, output sample_value,
                    input ready);
    modport sink   (input valid, input mode, input channel, input sample_value,
                    output ready);
endinterface

// ===== rtl/emgnf_out_if.sv =====
// ----------------------------------------------------------------------------
// emgnf_out_if
// Result channel: one qualified sample word with valid/ready.
// ----------------------------------------------------------------------------
interface emgnf_out_if
    import emgnf_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   channel_out;
    logic [SAMPLE_BITS-1:0] signal_level;
    logic [SAMPLE_BITS-1:0] floor_mean;
    logic                   active;
    logic                   peak_event;
    logic                   hold_event;

    modport source (output valid, output channel_out, output signal_level,
                    output floor_mean, output active, output peak_event,
                    output hold_event, input ready);
    modport sink   (input valid, input channel_out, input signal_level,
                    input floor_mean, input active, input peak_event,
                    input hold_event, output ready);
endinterface

// ===== rtl/emgnf_ram.sv =====
// ----------------------------------------------------------------------------
// emgnf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module emgnf_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/emgnf_front.sv =====
// ----------------------------------------------------------------------------
// emgnf_front
// Accepts input words, drops the ones with no effect, queues the rest.
// ----------------------------------------------------------------------------
module emgnf_front
    import emgnf_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    emgnf_in_if.sink          i_sample,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_pop
);
    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_q [Q_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_count;
    logic             accept;
    logic             keep;
    logic             push;
    logic             pop;

    // classify: unused modes and absent channels cause nothing
    always_comb begin
        case (i_sample.mode)
            MODE_SAMPLE:  keep = (32'(i_sample.channel) < CHANNELS);
            MODE_TICK:    keep = 1'b1;
            MODE_RESTART: keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign i_sample.ready = (r_count != QC_W'(Q_DEPTH));
    assign accept         = i_sample.valid && i_sample.ready;
    assign push           = accept && keep;
    assign pop            = i_cmd_pop && o_cmd_valid;

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{mode: i_sample.mode, channel: i_sample.channel,
                               sample_value: i_sample.sample_value};
        end
    end

    // queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/emgnf_back.sv =====
// ----------------------------------------------------------------------------
// emgnf_back
// Executes queued words: ring update, floor mean, crossings, hold timers.
// ----------------------------------------------------------------------------
module emgnf_back
    import emgnf_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    emgnf_out_if.source o_result
);
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int ADDR_W  = $clog2(CHANNELS * RING_DEPTH);
    localparam int SUM_MAX = ((1 << SAMPLE_BITS) - 1) * RING_DEPTH;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int PROD_W  = 2 * SUM_W;
    localparam int RECIP   = (1 << SUM_W) / RING_DEPTH;
    localparam logic [SUM_W-1:0] RECIP_V = SUM_W'(RECIP);
    localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(RING_DEPTH);
    localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(int'(SEED_RST) * RING_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // per-channel state
    logic [SUM_W-1:0]       r_sum   [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_mean  [CHANNELS];
    logic [PTR_W-1:0]       r_ptr   [CHANNELS];
    logic                   r_full  [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_prev  [CHANNELS];
    logic                   r_run   [CHANNELS];
    logic [HOLD_BITS-1:0]   r_ticks [CHANNELS];
    logic                   r_held  [CHANNELS];
    logic [SAMPLE_BITS-1:0] r_fill_seed;

    // item in flight
    logic [1:0]             r_state;
    logic [CH_W-1:0]        r_ch;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_admit;
    logic [ADDR_W-1:0]      r_addr;
    logic [PTR_W-1:0]       r_ptr_cur;
    logic [SUM_W-1:0]       r_new_sum;
    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_BITS-1:0] r_q0;
    logic [SUM_W-1:0]       r_qd;

    // result register
    logic                   r_out_valid;
    logic                   r_out_ch;
    logic [SAMPLE_BITS-1:0] r_out_level;
    logic [SAMPLE_BITS-1:0] r_out_mean;
    logic                   r_out_active;
    logic                   r_out_peak;
    logic                   r_out_hold;

    logic [CH_W-1:0]        ch_in;
    logic [SAMPLE_BITS:0]   admit_thr;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] ram_q;
    logic [SAMPLE_BITS-1:0] old_entry;
    logic                   ram_we;
    logic [SUM_W-1:0]       n_sum;
    logic [SUM_W-1:0]       sum_sel;
    logic [SUM_W-1:0]       seed_sum;
    logic [SUM_W-1:0]       rem;
    logic [SAMPLE_BITS-1:0] n_mean;
    logic [SAMPLE_BITS-1:0] n_level;
    logic                   active;
    logic                   hold_hit;
    logic                   run_a;
    logic                   held_a;
    logic                   rise;
    logic                   fall;
    logic                   peak;
    logic                   commit;

    // admission test against the current mean
    assign ch_in     = CH_W'(i_cmd.channel);
    assign admit_thr = {1'b0, r_mean[ch_in]}
                     + (SAMPLE_BITS + 1)'(i_cfg.sensitivity_offset >> OFFSET_SHIFT);
    assign rd_addr   = ADDR_W'(ch_in) * ADDR_W'(RING_DEPTH) + ADDR_W'(r_ptr[ch_in]);
    assign o_cmd_pop = (r_state == ST_IDLE);

    // ring storage, entries not yet written since restart read as the fill seed
    assign ram_we = (r_state == ST_READ) && r_admit;

    emgnf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (CHANNELS * RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (r_sample),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    assign old_entry = r_full[r_ch] ? ram_q : r_fill_seed;
    assign n_sum     = r_sum[r_ch] - SUM_W'(old_entry) + SUM_W'(r_sample);
    assign sum_sel   = r_admit ? n_sum : r_sum[r_ch];
    assign seed_sum  = SUM_W'(i_cfg.floor_seed) * DEPTH_V;

    // reciprocal quotient correction, then level and crossing logic
    always_comb begin
        rem      = r_new_sum - r_qd;
        n_mean   = r_q0 + SAMPLE_BITS'(rem >= DEPTH_V);
        n_level  = (r_sample > n_mean) ? (r_sample - n_mean) : '0;
        active   = (n_level != '0);
        hold_hit = active && r_run[r_ch] && (r_ticks[r_ch] >= i_cfg.hold_time)
                   && !r_held[r_ch];
        run_a    = hold_hit ? 1'b0 : r_run[r_ch];
        held_a   = r_held[r_ch] || hold_hit;
        rise     = active && (r_prev[r_ch] < i_cfg.sensitivity_offset)
                   && (n_level >= i_cfg.sensitivity_offset);
        fall     = active && !rise && (r_prev[r_ch] >= i_cfg.sensitivity_offset)
                   && (n_level < i_cfg.sensitivity_offset);
        peak     = (rise && !i_cfg.peak_on_end) || (fall && i_cfg.peak_on_end && !held_a);
    end

    assign commit = (r_state == ST_FIN) && (!r_out_valid || o_result.ready);

    // sequencer and channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill_seed <= SEED_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]   <= SUM_RST;
                r_mean[c]  <= SEED_RST;
                r_ptr[c]   <= '0;
                r_full[c]  <= 1'b0;
                r_prev[c]  <= '0;
                r_run[c]   <= 1'b0;
                r_ticks[c] <= '0;
                r_held[c]  <= 1'b0;
            end
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.mode)
                            MODE_SAMPLE: begin
                                r_ch      <= ch_in;
                                r_sample  <= i_cmd.sample_value;
                                r_admit   <= ({1'b0, i_cmd.sample_value} < admit_thr);
                                r_addr    <= rd_addr;
                                r_ptr_cur <= r_ptr[ch_in];
                                r_state   <= ST_READ;
                            end
                            MODE_TICK: begin
                                for (int c = 0; c < CHANNELS; c++) begin
                                    if (r_run[c] && r_ticks[c] != TICKS_MAX) begin
                                        r_ticks[c] <= r_ticks[c] + 1'b1;
                                    end
                                end
                            end
                            MODE_RESTART: begin
                                r_fill_seed <= i_cfg.floor_seed;
                                for (int c = 0; c < CHANNELS; c++) begin
                                    r_sum[c]  <= seed_sum;
                                    r_mean[c] <= i_cfg.floor_seed;
                                    r_ptr[c]  <= '0;
                                    r_full[c] <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    if (r_admit) begin
                        r_sum[r_ch] <= n_sum;
                        if (r_ptr_cur == PTR_W'(RING_DEPTH - 1)) begin
                            r_ptr[r_ch]  <= '0;
                            r_full[r_ch] <= 1'b1;
                        end else begin
                            r_ptr[r_ch] <= r_ptr_cur + 1'b1;
                        end
                    end
                    r_new_sum <= sum_sel;
                    r_prod    <= PROD_W'(sum_sel) * PROD_W'(RECIP_V);
                    r_state   <= ST_MUL;
                end
                ST_MUL: begin
                    r_q0    <= r_prod[SUM_W +: SAMPLE_BITS];
                    r_qd    <= SUM_W'(r_prod[SUM_W +: SAMPLE_BITS]) * DEPTH_V;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (commit) begin
                        r_mean[r_ch] <= n_mean;
                        r_prev[r_ch] <= n_level;
                        r_held[r_ch] <= rise ? 1'b0 : held_a;
                        r_run[r_ch]  <= rise ? 1'b1 : (fall ? 1'b0 : run_a);
                        if (rise) begin
                            r_ticks[r_ch] <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_ch     <= r_ch[0];
            r_out_level  <= n_level;
            r_out_mean   <= n_mean;
            r_out_active <= active;
            r_out_peak   <= peak;
            r_out_hold   <= hold_hit;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.channel_out  = r_out_ch;
    assign o_result.signal_level = r_out_level;
    assign o_result.floor_mean   = r_out_mean;
    assign o_result.active       = r_out_active;
    assign o_result.peak_event   = r_out_peak;
    assign o_result.hold_event   = r_out_hold;
endmodule

// ===== rtl/emg_noise_floor_peak_hold_detector_core.sv =====
// ----------------------------------------------------------------------------
// emg_noise_floor_peak_hold_detector_core
// Per-channel muscle signal qualifier with adaptive noise floor and hold timer.
// ----------------------------------------------------------------------------
// A sample word passes through the back end in steps: ring read, reciprocal
// multiply for the floor mean, quotient scaling, correction and crossing
// resolve; a timer tick or a floor restart is executed while idle. A two-word
// queue sits behind the input, and the result register lets the next word
// start while a result waits to be taken. Restart needs no clearing pass:
// ring entries not yet rewritten since the last restart read as the seed
// latched at that restart. Only sample words produce a result.
module emg_noise_floor_peak_hold_detector_core
    import emgnf_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    emgnf_in_if.sink                  i_sample,
    emgnf_out_if.source               o_result,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata
);
    t_cfg r_cfg;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensitivity_offset <= OFFSET_RST;
            r_cfg.hold_time          <= HOLD_RST;
            r_cfg.peak_on_end        <= PEAK_ON_END_RST;
            r_cfg.floor_seed         <= SEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFFSET:      r_cfg.sensitivity_offset <= i_cfg_wdata[OFFSET_BITS-1:0];
                CFG_HOLD_TIME:   r_cfg.hold_time          <= i_cfg_wdata[HOLD_BITS-1:0];
                CFG_PEAK_ON_END: r_cfg.peak_on_end        <= i_cfg_wdata[0];
                CFG_FLOOR_SEED:  r_cfg.floor_seed         <= i_cfg_wdata[SAMPLE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input classification and queue
    emgnf_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // execution and result register
    emgnf_back #(
        .CHANNELS   (CHANNELS),
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result)
    );
endmodule

// ===== bench/emgnf_checker.sv =====
// ----------------------------------------------------------------------------
// emgnf_checker
// Watches the sample and result channels and the register port of the noise
// floor detector, keeps its own copy of the per-channel floors, levels and
// hold timers, and compares every result word field by field with the
// qualification it predicts for the oldest pending sample word.
// ----------------------------------------------------------------------------
module emgnf_checker
    import emgnf_pkg::*;
#(
    parameter int CHANNELS   = CHANNELS_DEF,
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    emgnf_in_if                       in_mon,
    emgnf_out_if                      out_mon,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output int                        o_mismatches,
    output int                        o_words_due,
    output int                        o_results,
    output int                        o_peaks,
    output int                        o_holds
);

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(RING_DEPTH);
    localparam int PTR_BITS = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    typedef struct packed {
        logic                   channel;
        logic [SAMPLE_BITS-1:0] level;
        logic [SAMPLE_BITS-1:0] mean;
        logic                   active;
        logic                   peak;
        logic                   hold;
    } t_qualified;

    // predicted register file and per-channel state
    t_cfg                   regs;
    logic [SAMPLE_BITS-1:0] ring       [CHANNELS][RING_DEPTH];
    logic [SUM_BITS-1:0]    floor_sum  [CHANNELS];
    logic [PTR_BITS-1:0]    fill_ptr   [CHANNELS];
    logic [SAMPLE_BITS-1:0] last_level [CHANNELS];
    logic                   hold_armed [CHANNELS];
    logic [HOLD_BITS-1:0]   hold_ticks [CHANNELS];
    logic                   held       [CHANNELS];

    t_qualified qualified_q[$];
    int mismatches = 0;
    int results    = 0;
    int peaks      = 0;
    int holds      = 0;

    // every ring back to the current seed
    task automatic refill_floors();
        for (int c = 0; c < CHANNELS; c++) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                ring[c][i] = regs.floor_seed;
            end
            floor_sum[c] = SUM_BITS'(int'(regs.floor_seed) * RING_DEPTH);
            fill_ptr[c]  = '0;
        end
    endtask

    task automatic clear_state();
        regs.sensitivity_offset = OFFSET_RST;
        regs.hold_time          = HOLD_RST;
        regs.peak_on_end        = PEAK_ON_END_RST;
        regs.floor_seed         = SEED_RST;
        refill_floors();
        for (int c = 0; c < CHANNELS; c++) begin
            last_level[c] = '0;
            hold_armed[c] = 1'b0;
            hold_ticks[c] = '0;
            held[c]       = 1'b0;
        end
        qualified_q.delete();
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_OFFSET:      regs.sensitivity_offset = data[OFFSET_BITS-1:0];
            CFG_HOLD_TIME:   regs.hold_time          = data[HOLD_BITS-1:0];
            CFG_PEAK_ON_END: regs.peak_on_end        = data[0];
            CFG_FLOOR_SEED:  regs.floor_seed         = data[SAMPLE_BITS-1:0];
            default: ;
        endcase
    endtask

    // floor update, level and crossing analysis for one accepted word
    task automatic qualify_word(input t_cmd w);
        int         ch;
        int         mean;
        int         lvl;
        int         prev;
        int         off;
        logic       pk;
        logic       hd;
        t_qualified want;
        ch  = int'(w.channel);
        off = int'(regs.sensitivity_offset);
        case (w.mode)
            MODE_TICK: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (hold_armed[c] && hold_ticks[c] != TICKS_MAX) begin
                        hold_ticks[c] = hold_ticks[c] + 1'b1;
                    end
                end
            end
            MODE_RESTART: begin
                refill_floors();
            end
            MODE_SAMPLE: begin
                if (ch < CHANNELS) begin
                    // quiet samples join the noise ring
                    mean = int'(floor_sum[ch]) / RING_DEPTH;
                    if (int'(w.sample_value) < mean + off / OFFSET_DIVISOR) begin
                        floor_sum[ch] = floor_sum[ch] - ring[ch][fill_ptr[ch]]
                                        + w.sample_value;
                        ring[ch][fill_ptr[ch]] = w.sample_value;
                        fill_ptr[ch] = PTR_BITS'((int'(fill_ptr[ch]) + 1) % RING_DEPTH);
                    end
                    mean = int'(floor_sum[ch]) / RING_DEPTH;
                    prev = int'(last_level[ch]);
                    lvl  = (int'(w.sample_value) > mean) ? int'(w.sample_value) - mean : 0;
                    pk   = 1'b0;
                    hd   = 1'b0;
                    last_level[ch] = SAMPLE_BITS'(lvl);
                    // zero level leaves timer and marks untouched
                    if (lvl > 0) begin
                        if (hold_armed[ch] && hold_ticks[ch] >= regs.hold_time && !held[ch]) begin
                            held[ch]       = 1'b1;
                            hd             = 1'b1;
                            hold_armed[ch] = 1'b0;
                        end
                        if (prev < off && lvl >= off) begin
                            hold_armed[ch] = 1'b1;
                            hold_ticks[ch] = '0;
                            held[ch]       = 1'b0;
                            pk             = !regs.peak_on_end;
                        end else if (prev >= off && lvl < off) begin
                            hold_armed[ch] = 1'b0;
                            pk             = regs.peak_on_end && !held[ch];
                        end
                    end
                    want.channel = w.channel;
                    want.level   = SAMPLE_BITS'(lvl);
                    want.mean    = SAMPLE_BITS'(mean);
                    want.active  = (lvl > 0);
                    want.peak    = pk;
                    want.hold    = hd;
                    qualified_q.push_back(want);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_word();
        t_qualified want;
        if (qualified_q.size() == 0) begin
            $error("result word on channel %0d with no sample outstanding",
                   out_mon.channel_out);
            mismatches++;
        end else begin
            want = qualified_q.pop_front();
            check_field("channel_out",  16'(want.channel), 16'(out_mon.channel_out));
            check_field("signal_level", 16'(want.level),   16'(out_mon.signal_level));
            check_field("floor_mean",   16'(want.mean),    16'(out_mon.floor_mean));
            check_field("active",       16'(want.active),  16'(out_mon.active));
            check_field("peak_event",   16'(want.peak),    16'(out_mon.peak_event));
            check_field("hold_event",   16'(want.hold),    16'(out_mon.hold_event));
        end
        results++;
        if (out_mon.peak_event === 1'b1) peaks++;
        if (out_mon.hold_event === 1'b1) holds++;
    endtask

    // sample both channels and the register port at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_cfg_we) begin
                write_register(i_cfg_index, i_cfg_wdata);
            end
            if (in_mon.valid && in_mon.ready) begin
                qualify_word({in_mon.mode, in_mon.channel, in_mon.sample_value});
            end
            if (out_mon.valid && out_mon.ready) begin
                check_word();
            end
        end
        o_mismatches <= mismatches;
        o_words_due  <= qualified_q.size();
        o_results    <= results;
        o_peaks      <= peaks;
        o_holds      <= holds;
    end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the noise floor peak/hold detector: directed words
// for the edge cases, a longer tick run against a longer hold, then phases of
// random detection bursts and noise under varied settings and flow control.
// ----------------------------------------------------------------------------
module testbench;
    import emgnf_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int RANDOM_WORDS   = 560;
    localparam int RANDOM_PHASES  = 8;
    localparam int LONG_HOLD      = 40;
    localparam int LONG_TICKS     = 45;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    emgnf_in_if  sample_if ();
    emgnf_out_if result_if ();

    int mismatches;
    int words_due;
    int results_seen;
    int peaks_seen;
    int holds_seen;

    // stimulus bookkeeping
    int gap_pct = 0;
    int stall_pct;
    int cycles = 0;
    int words_sent = 0;
    int samples_sent = 0;
    int ticks_sent = 0;
    int restarts_sent = 0;
    int ignored_sent = 0;
    int phases = 0;
    int cur_off = 100;
    int cur_hold = 300;
    int cur_seed = 512;

    always #(CLK_HALF) clk = ~clk;

    emg_noise_floor_peak_hold_detector_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_sample    (sample_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    emgnf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_mon       (sample_if),
        .out_mon      (result_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_words_due  (words_due),
        .o_results    (results_seen),
        .o_peaks      (peaks_seen),
        .o_holds      (holds_seen)
    );

    // result side back-pressure
    always @(posedge clk) begin
        result_if.ready <= (int'($urandom_range(99, 0)) >= stall_pct);
    end

    // run-away guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, words_due);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int pick(input int lo, input int hi);
        return int'($urandom_range(hi, lo));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clamp_sample(input int v);
        if (v < 0) return '0;
        if (v > (1 << SAMPLE_BITS) - 1) return '1;
        return SAMPLE_BITS'(v);
    endfunction

    // one word on the sample channel, valid stays up after acceptance
    task automatic send_word(input logic [MODE_BITS-1:0] mode, input logic ch,
                             input logic [SAMPLE_BITS-1:0] value);
        while (pick(0, 99) < gap_pct) begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid        <= 1'b1;
        sample_if.mode         <= mode;
        sample_if.channel      <= ch;
        sample_if.sample_value <= value;
        do @(posedge clk); while (!sample_if.ready);
        case (mode)
            MODE_SAMPLE:  samples_sent++;
            MODE_TICK:    ticks_sent++;
            MODE_RESTART: restarts_sent++;
            default:      ignored_sent++;
        endcase
        if (mode != MODE_UNUSED) words_sent++;
    endtask

    task automatic send_sample(input logic ch, input int v);
        send_word(MODE_SAMPLE, ch, clamp_sample(v));
    endtask

    // tick and restart carry random filler in the unused fields
    task automatic send_tick();
        send_word(MODE_TICK, 1'(pick(0, 1)), SAMPLE_BITS'(pick(0, 1023)));
    endtask

    task automatic send_restart();
        send_word(MODE_RESTART, 1'(pick(0, 1)), SAMPLE_BITS'(pick(0, 1023)));
    endtask

    // drop valid and wait until every result is back and the back end is quiet
    task automatic settle();
        sample_if.valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_BITS'(value);
        @(posedge clk);
    endtask

    task automatic load_settings(input int off, input int hold, input int peak,
                                 input int seed);
        settle();
        write_reg(CFG_OFFSET, off);
        write_reg(CFG_HOLD_TIME, hold);
        write_reg(CFG_PEAK_ON_END, peak);
        write_reg(CFG_FLOOR_SEED, seed);
        cfg_we   <= 1'b0;
        cur_off  = off;
        cur_hold = hold;
        cur_seed = seed;
        phases++;
    endtask

    task automatic set_idle(input int style);
        case (style)
            0: begin gap_pct = 0;  stall_pct <= 0;  end
            1: begin gap_pct = 50; stall_pct <= 0;  end
            2: begin gap_pct = 0;  stall_pct <= 50; end
            default: begin gap_pct = 8; stall_pct <= 8; end
        endcase
    endtask

    // quiet lead-in, rising crossing, ticks with active samples, falling crossing
    task automatic detection_burst(input logic ch);
        int base;
        int span;
        if (pick(0, 99) < 40) send_restart();
        base = cur_seed;
        span = (cur_hold < 10) ? cur_hold + 2 : 12;
        repeat (pick(1, 4)) send_sample(ch, base - pick(0, 12));
        send_sample(ch, base + cur_off + pick(0, 40));
        repeat (pick(0, 3)) begin
            repeat (pick(0, span)) send_tick();
            send_sample(ch, base + cur_off + pick(0, 60));
            if (pick(0, 3) == 0) send_sample(!ch, pick(0, 1023));
        end
        if (pick(0, 3) == 0) send_sample(ch, base - pick(0, 8));
        send_sample(ch, base + pick(1, (cur_off > 1) ? cur_off - 1 : 1));
        repeat (pick(0, 2)) send_sample(ch, base - pick(0, 12));
    endtask

    task automatic noise_word();
        int roll;
        roll = pick(0, 99);
        if (roll < 50) send_sample(1'(pick(0, 1)), pick(0, 1023));
        else if (roll < 75) send_tick();
        else if (roll < 85) send_restart();
        else send_word(MODE_UNUSED, 1'(pick(0, 1)), SAMPLE_BITS'(pick(0, 1023)));
    endtask

    task automatic random_phase(input int p);
        int stop_at;
        case (p)
            0: load_settings(100, 3, 0, 512);
            1: load_settings(1023, 0, 1, 0);
            2: load_settings(0, 65535, 0, 1023);
            default: load_settings(pick(8, 400),
                                   (pick(0, 3) == 0) ? pick(0, 65535) : pick(0, 10),
                                   pick(0, 1), pick(0, 1023));
        endcase
        set_idle(p % 4);
        stop_at = words_sent + RANDOM_WORDS / RANDOM_PHASES;
        while (words_sent < stop_at) begin
            if (pick(0, 99) < 70) detection_burst(1'(pick(0, 1)));
            else noise_word();
        end
    endtask

    initial begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= CFG_OFFSET;
        cfg_wdata              <= '0;
        sample_if.valid        <= 1'b0;
        sample_if.mode         <= MODE_SAMPLE;
        sample_if.channel      <= 1'b0;
        sample_if.sample_value <= '0;
        stall_pct              <= 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // peak on rising crossing, short hold
        load_settings(100, 2, 0, 512);
        set_idle(0);
        send_restart();
        send_sample(1'b0, 0);
        send_sample(1'b0, 1023);
        repeat (3) send_tick();
        send_sample(1'b0, 1023);
        send_sample(1'b0, 1023);
        send_sample(1'b1, 700);
        send_sample(1'b0, 520);
        send_sample(1'b0, 0);
        send_tick();
        send_word(MODE_UNUSED, 1'b1, '1);
        send_sample(1'b1, 512);
        send_sample(1'b0, 1023);

        // peak on falling crossing, suppressed once held
        load_settings(60, 1, 1, 200);
        send_restart();
        send_sample(1'b0, 300);
        send_sample(1'b0, 230);
        send_sample(1'b0, 300);
        repeat (2) send_tick();
        send_sample(1'b0, 300);
        send_sample(1'b0, 230);

        // zero offset never rises
        load_settings(0, 5, 0, 300);
        send_restart();
        send_sample(1'b1, 1023);
        send_sample(1'b1, 0);
        send_sample(1'b1, 1023);

        // longer tick run just past a longer hold
        load_settings(100, LONG_HOLD, 0, 512);
        send_restart();
        send_sample(1'b0, 1023);
        repeat (LONG_TICKS) send_tick();
        send_sample(1'b0, 1023);
        send_sample(1'b0, 1023);

        for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);
        settle();

        $display("sent %0d samples, %0d ticks, %0d restarts, %0d unused words in %0d settings",
                 samples_sent, ticks_sent, restarts_sent, ignored_sent, phases);
        $display("checked %0d results with %0d peaks and %0d holds, %0d mismatches",
                 results_seen, peaks_seen, holds_seen, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/emgnf_pkg.sv
rtl/emgnf_in_if.sv
rtl/emgnf_out_if.sv
rtl/emgnf_ram.sv
rtl/emgnf_front.sv
rtl/emgnf_back.sv
rtl/emg_noise_floor_peak_hold_detector_core.sv
bench/emgnf_checker.sv
bench/testbench.sv
